// ===== rtl/divisor_count_and_sum_assert.svh =====
// Assertion macros shared by the checker of the divisor count and sum block.
`ifndef DIVISOR_COUNT_AND_SUM_ASSERT_SVH
`define DIVISOR_COUNT_AND_SUM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCS_ASSERT_SAME(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("dcs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DCS_ASSERT_NEXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("dcs assertion failed");

`endif

// ===== rtl/dcs_pkg.sv =====
// Package of the divisor count and sum block: payload types, codes and microcode.
package dcs_pkg;

  // Field widths.
  localparam int VAL_W    = 16;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 8;
  localparam int SUM_W    = 32;
  localparam int DEF_MAX_N = 65535;

  // Result status codes.
  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BUILT     = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_RANGE     = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_NOT_BUILT = 2'd3;

  // Operation codes.
  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic             op;
    logic [VAL_W-1:0] value;
  } dcs_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  divisor_count;
    logic [SUM_W-1:0]  divisor_sum;
  } dcs_out_t;

  // Microcode word layout.
  localparam int UPC_W  = 5;
  localparam int ACT_W  = 5;
  localparam int COND_W = 4;

  // Datapath actions.
  localparam logic [ACT_W-1:0] A_NOP        = 5'd0;
  localparam logic [ACT_W-1:0] A_LATCH      = 5'd1;
  localparam logic [ACT_W-1:0] A_I_INIT     = 5'd2;
  localparam logic [ACT_W-1:0] A_J_SET      = 5'd3;
  localparam logic [ACT_W-1:0] A_WRITE      = 5'd4;
  localparam logic [ACT_W-1:0] A_I_DEC      = 5'd5;
  localparam logic [ACT_W-1:0] A_EMIT_BUILD = 5'd6;
  localparam logic [ACT_W-1:0] A_Q_INIT     = 5'd7;
  localparam logic [ACT_W-1:0] A_READ_X     = 5'd8;
  localparam logic [ACT_W-1:0] A_P_LOAD     = 5'd9;
  localparam logic [ACT_W-1:0] A_DIV_GO     = 5'd10;
  localparam logic [ACT_W-1:0] A_X_UPD      = 5'd11;
  localparam logic [ACT_W-1:0] A_TERM       = 5'd12;
  localparam logic [ACT_W-1:0] A_CNT        = 5'd13;
  localparam logic [ACT_W-1:0] A_SUM        = 5'd14;
  localparam logic [ACT_W-1:0] A_EMIT_OK    = 5'd15;
  localparam logic [ACT_W-1:0] A_EMIT_NB    = 5'd16;
  localparam logic [ACT_W-1:0] A_EMIT_RANGE = 5'd17;

  // Jump conditions.
  localparam logic [COND_W-1:0] C_NEVER     = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS    = 4'd1;
  localparam logic [COND_W-1:0] C_NO_START  = 4'd2;
  localparam logic [COND_W-1:0] C_QUERY     = 4'd3;
  localparam logic [COND_W-1:0] C_TOP_LT2   = 4'd4;
  localparam logic [COND_W-1:0] C_J_NEXT_OK = 4'd5;
  localparam logic [COND_W-1:0] C_I_MORE    = 4'd6;
  localparam logic [COND_W-1:0] C_NOT_BUILT = 4'd7;
  localparam logic [COND_W-1:0] C_OUT_RANGE = 4'd8;
  localparam logic [COND_W-1:0] C_X_LE1     = 4'd9;
  localparam logic [COND_W-1:0] C_DIV_BUSY  = 4'd10;
  localparam logic [COND_W-1:0] C_SAME_P    = 4'd11;
  localparam logic [COND_W-1:0] C_X_GT1     = 4'd12;

  // Program step addresses.
  localparam logic [UPC_W-1:0] U_IDLE     = 5'd0;
  localparam logic [UPC_W-1:0] U_DISPATCH = 5'd1;
  localparam logic [UPC_W-1:0] U_B_INIT   = 5'd2;
  localparam logic [UPC_W-1:0] U_B_JSET   = 5'd3;
  localparam logic [UPC_W-1:0] U_B_WRITE  = 5'd4;
  localparam logic [UPC_W-1:0] U_B_NEXTI  = 5'd5;
  localparam logic [UPC_W-1:0] U_B_DONE   = 5'd6;
  localparam logic [UPC_W-1:0] U_Q_INIT   = 5'd7;
  localparam logic [UPC_W-1:0] U_Q_RANGE  = 5'd8;
  localparam logic [UPC_W-1:0] U_Q_READ   = 5'd9;
  localparam logic [UPC_W-1:0] U_Q_PLOAD  = 5'd10;
  localparam logic [UPC_W-1:0] U_Q_DIVGO  = 5'd11;
  localparam logic [UPC_W-1:0] U_Q_DIVW   = 5'd12;
  localparam logic [UPC_W-1:0] U_Q_XUPD   = 5'd13;
  localparam logic [UPC_W-1:0] U_Q_TERM   = 5'd14;
  localparam logic [UPC_W-1:0] U_Q_CNT    = 5'd15;
  localparam logic [UPC_W-1:0] U_Q_SUM    = 5'd16;
  localparam logic [UPC_W-1:0] U_Q_OK     = 5'd17;
  localparam logic [UPC_W-1:0] U_E_NB     = 5'd18;
  localparam logic [UPC_W-1:0] U_E_RANGE  = 5'd19;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [UPC_W-1:0]  target;
  } ucode_t;

  // Control store: one word per step; a true condition jumps to target.
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    case (addr)
      U_IDLE:     w = '{A_LATCH,      C_NO_START,  U_IDLE};
      U_DISPATCH: w = '{A_NOP,        C_QUERY,     U_Q_INIT};
      U_B_INIT:   w = '{A_I_INIT,     C_TOP_LT2,   U_B_DONE};
      U_B_JSET:   w = '{A_J_SET,      C_NEVER,     U_IDLE};
      U_B_WRITE:  w = '{A_WRITE,      C_J_NEXT_OK, U_B_WRITE};
      U_B_NEXTI:  w = '{A_I_DEC,      C_I_MORE,    U_B_JSET};
      U_B_DONE:   w = '{A_EMIT_BUILD, C_ALWAYS,    U_IDLE};
      U_Q_INIT:   w = '{A_Q_INIT,     C_NOT_BUILT, U_E_NB};
      U_Q_RANGE:  w = '{A_NOP,        C_OUT_RANGE, U_E_RANGE};
      U_Q_READ:   w = '{A_READ_X,     C_X_LE1,     U_Q_OK};
      U_Q_PLOAD:  w = '{A_P_LOAD,     C_NEVER,     U_IDLE};
      U_Q_DIVGO:  w = '{A_DIV_GO,     C_NEVER,     U_IDLE};
      U_Q_DIVW:   w = '{A_NOP,        C_DIV_BUSY,  U_Q_DIVW};
      U_Q_XUPD:   w = '{A_X_UPD,      C_NEVER,     U_IDLE};
      U_Q_TERM:   w = '{A_TERM,       C_SAME_P,    U_Q_DIVGO};
      U_Q_CNT:    w = '{A_CNT,        C_NEVER,     U_IDLE};
      U_Q_SUM:    w = '{A_SUM,        C_X_GT1,     U_Q_PLOAD};
      U_Q_OK:     w = '{A_EMIT_OK,    C_ALWAYS,    U_IDLE};
      U_E_NB:     w = '{A_EMIT_NB,    C_ALWAYS,    U_IDLE};
      U_E_RANGE:  w = '{A_EMIT_RANGE, C_ALWAYS,    U_IDLE};
      default:    w = '{A_NOP,        C_ALWAYS,    U_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/dcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dcs_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module dcs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dcs_pkg::VAL_W-1:0] dividend,
  input  logic [dcs_pkg::VAL_W-1:0] divisor,
  output logic                      busy,
  output logic [dcs_pkg::VAL_W-1:0] quotient
);

  localparam int W    = dcs_pkg::VAL_W;
  localparam int CW   = $clog2(W + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W+1:0]  trial;

  // Trial subtraction of the divisor from the shifted remainder.
  assign trial = {1'b0, rem_r, quo_r[W-1]} - {2'b00, dvs_r};

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    if (start) begin
      cnt_nxt = CW'(W);
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!trial[W+1]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
    end
  end

  // Iteration counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

// ===== rtl/divisor_count_and_sum.sv =====
// Top level of the divisor count and sum block: microcoded sequencer and datapath.
//
// Use: a beat on the input channel is accepted at a clock edge with start high and
// busy low. Operation build fills the smallest-prime-factor table up to the
// effective limit, min(limit, MAX_N), and answers status "build done". Operation
// query factors value and answers its divisor count and divisor sum, or an error
// status (table not built, value out of range) with zero count and sum.
// Every item gives one result beat, shown for one cycle with out_strobe high;
// the receiver cannot stall it. The cfg channel writes limit and clears the
// built flag; it is always ready. The user must use it only while the block is
// idle; the block itself does not enforce this. A build's length is set by its
// table writes, one per cycle, and a query's by the bit-serial divider, which
// runs once per prime factor counted with multiplicity.
// The result appears the cycle after the last step, when busy is low again.
// Reset: limit returns to 65535, the table counts as not built, the table
// memory itself is not cleared.
module divisor_count_and_sum #(
  parameter int MAX_N = dcs_pkg::DEF_MAX_N
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  dcs_pkg::dcs_in_t                    in_data,
  output logic                                out_strobe,
  output dcs_pkg::dcs_out_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dcs_pkg::VAL_W-1:0]           cfg_data
);

  localparam int DEPTH = MAX_N + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = dcs_pkg::VAL_W;

  // Control state.
  logic [dcs_pkg::UPC_W-1:0] upc_r, upc_nxt;
  logic                      built_r, built_nxt;
  logic [VW-1:0]             limit_r, limit_nxt;
  logic                      out_strobe_r, out_strobe_nxt;

  // Datapath registers.
  logic                      op_r, op_nxt;
  logic [VW-1:0]             value_r, value_nxt;
  logic [VW-1:0]             i_r, i_nxt;
  logic [VW:0]               j_r, j_nxt;
  logic [VW-1:0]             x_r, x_nxt;
  logic [VW-1:0]             p_r, p_nxt;
  logic [VW-1:0]             pw_r, pw_nxt;
  logic [VW:0]               term_r, term_nxt;
  logic [4:0]                e_r, e_nxt;
  logic [dcs_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [dcs_pkg::SUM_W-1:0] sum_r, sum_nxt;
  dcs_pkg::dcs_out_t         out_data_r, out_data_nxt;

  dcs_pkg::ucode_t           uw;
  logic                      jump;
  logic [VW-1:0]             top;
  logic [VW-1:0]             rd_val;
  logic [5:0]                e_inc;

  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [AW-1:0]             ram_rdata;
  logic                      div_start, div_busy;
  logic [VW-1:0]             div_quo;

  // Effective limit of the table.
  assign top = (32'(limit_r) > MAX_N) ? VW'(MAX_N) : limit_r;

  // Current control word.
  assign uw = dcs_pkg::ucode_rom(upc_r);

  assign rd_val = VW'(ram_rdata);
  assign e_inc  = {1'b0, e_r} + 6'd1;

  // Jump condition select.
  always_comb begin
    case (uw.cond)
      dcs_pkg::C_NEVER:     jump = 1'b0;
      dcs_pkg::C_ALWAYS:    jump = 1'b1;
      dcs_pkg::C_NO_START:  jump = !start;
      dcs_pkg::C_QUERY:     jump = (op_r == dcs_pkg::OP_QUERY);
      dcs_pkg::C_TOP_LT2:   jump = (top < 16'd2);
      dcs_pkg::C_J_NEXT_OK: jump = ((j_r + {1'b0, i_r}) <= {1'b0, top});
      dcs_pkg::C_I_MORE:    jump = (i_r > 16'd2);
      dcs_pkg::C_NOT_BUILT: jump = !built_r;
      dcs_pkg::C_OUT_RANGE: jump = (value_r == '0) || (value_r > top);
      dcs_pkg::C_X_LE1:     jump = (x_r <= 16'd1);
      dcs_pkg::C_DIV_BUSY:  jump = div_busy;
      dcs_pkg::C_SAME_P:    jump = (x_r > 16'd1) && (rd_val == p_r);
      dcs_pkg::C_X_GT1:     jump = (x_r > 16'd1);
      default:              jump = 1'b0;
    endcase
  end

  assign upc_nxt = jump ? uw.target : upc_r + 1'b1;

  // Datapath actions.
  always_comb begin
    op_nxt         = op_r;
    value_nxt      = value_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    x_nxt          = x_r;
    p_nxt          = p_r;
    pw_nxt         = pw_r;
    term_nxt       = term_r;
    e_nxt          = e_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    built_nxt      = built_r;
    limit_nxt      = limit_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = AW'(j_r);
    ram_raddr      = AW'(x_r);
    div_start      = 1'b0;
    case (uw.act)
      dcs_pkg::A_NOP: begin
      end
      dcs_pkg::A_LATCH: begin
        op_nxt    = in_data.op;
        value_nxt = in_data.value;
      end
      dcs_pkg::A_I_INIT: begin
        i_nxt = top;
      end
      dcs_pkg::A_J_SET: begin
        j_nxt = {1'b0, i_r};
      end
      dcs_pkg::A_WRITE: begin
        ram_we = 1'b1;
        j_nxt  = j_r + {1'b0, i_r};
      end
      dcs_pkg::A_I_DEC: begin
        i_nxt = i_r - 1'b1;
      end
      dcs_pkg::A_EMIT_BUILD: begin
        built_nxt      = 1'b1;
        out_strobe_nxt = 1'b1;
        out_data_nxt   = '{dcs_pkg::STATUS_BUILT, '0, '0};
      end
      dcs_pkg::A_Q_INIT: begin
        x_nxt     = value_r;
        count_nxt = 8'd1;
        sum_nxt   = 32'd1;
      end
      dcs_pkg::A_READ_X: begin
        ram_re = 1'b1;
      end
      dcs_pkg::A_P_LOAD: begin
        p_nxt    = (rd_val < 16'd2) ? x_r : rd_val;
        pw_nxt   = 16'd1;
        term_nxt = 17'd1;
        e_nxt    = '0;
      end
      dcs_pkg::A_DIV_GO: begin
        div_start = 1'b1;
      end
      dcs_pkg::A_X_UPD: begin
        x_nxt     = div_quo;
        pw_nxt    = VW'(32'(pw_r) * 32'(p_r));
        e_nxt     = e_r + 1'b1;
        ram_re    = 1'b1;
        ram_raddr = AW'(div_quo);
      end
      dcs_pkg::A_TERM: begin
        term_nxt = term_r + {1'b0, pw_r};
      end
      dcs_pkg::A_CNT: begin
        count_nxt = 8'(16'(count_r) * 16'(e_inc));
      end
      dcs_pkg::A_SUM: begin
        sum_nxt = 32'(64'(sum_r) * 64'(term_r));
      end
      dcs_pkg::A_EMIT_OK: begin
        out_strobe_nxt = 1'b1;
        out_data_nxt   = '{dcs_pkg::STATUS_OK, count_r, sum_r};
      end
      dcs_pkg::A_EMIT_NB: begin
        out_strobe_nxt = 1'b1;
        out_data_nxt   = '{dcs_pkg::STATUS_NOT_BUILT, '0, '0};
      end
      dcs_pkg::A_EMIT_RANGE: begin
        out_strobe_nxt = 1'b1;
        out_data_nxt   = '{dcs_pkg::STATUS_RANGE, '0, '0};
      end
      default: begin
      end
    endcase
    // A limit write drops the table.
    if (cfg_valid && cfg_ready) begin
      limit_nxt = cfg_data;
      built_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r        <= dcs_pkg::U_IDLE;
      built_r      <= 1'b0;
      limit_r      <= 16'hFFFF;
      out_strobe_r <= 1'b0;
    end else begin
      upc_r        <= upc_nxt;
      built_r      <= built_nxt;
      limit_r      <= limit_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    value_r    <= value_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    x_r        <= x_nxt;
    p_r        <= p_nxt;
    pw_r       <= pw_nxt;
    term_r     <= term_nxt;
    e_r        <= e_nxt;
    count_r    <= count_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

  // Smallest-prime-factor table.
  dcs_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (AW'(i_r)),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // Divider for stripping one prime factor.
  dcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (x_r),
    .divisor  (p_r),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign busy       = (upc_r != dcs_pkg::U_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;
  assign cfg_ready  = 1'b1;

endmodule

// ===== rtl/dcs_checker.sv =====
// Port-level checker of the divisor count and sum block, with its bind.
`include "divisor_count_and_sum_assert.svh"

module dcs_port_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input dcs_pkg::dcs_out_t out_data
);

  logic accept;
  logic err_beat;
  logic ok_beat;
  logic zero_payload;

  assign accept       = start && !busy;
  assign err_beat     = out_strobe && (out_data.status != dcs_pkg::STATUS_OK);
  assign ok_beat      = out_strobe && (out_data.status == dcs_pkg::STATUS_OK);
  assign zero_payload = (out_data.divisor_count == '0) && (out_data.divisor_sum == '0);

  // An accepted item makes the block busy in the next cycle.
  `DCS_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)

  // A result beat only follows a busy cycle and shows the block idle again.
  `DCS_ASSERT_SAME(a_result_after_work, clk, rst_n, out_strobe, $past(busy) && !busy)

  // Results other than a successful query carry zero count and sum.
  `DCS_ASSERT_SAME(a_err_zero, clk, rst_n, err_beat, zero_payload)

  // A successful query never reports both a zero count and a zero sum.
  `DCS_ASSERT_SAME(a_ok_count, clk, rst_n, ok_beat, !zero_payload)

endmodule

bind divisor_count_and_sum dcs_port_checker u_dcs_checker (.*);

// ===== bench/dcs_checker.sv =====
`timescale 1ns / 1ps
// Checker of the divisor count and sum block: predicts each answer and compares the result beats.
module dcs_checker #(
  parameter int MAX_N = dcs_pkg::DEF_MAX_N
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  dcs_pkg::dcs_in_t          in_data,
  input  logic                      out_strobe,
  input  dcs_pkg::dcs_out_t         out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [dcs_pkg::VAL_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending
);

  localparam int PRINT_CAP = 30;

  // Predicted state of the block: the limit register and the built flag.
  logic [dcs_pkg::VAL_W-1:0] limit_reg;
  bit                        table_ready;
  dcs_pkg::dcs_out_t         answer_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    if (fail_count < PRINT_CAP) begin
      $display("ERROR at %0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    end
    fail_count++;
  endtask

  // Appends one predicted answer behind those already waiting.
  function automatic void store_answer(input dcs_pkg::dcs_out_t ans);
    answer_q = {answer_q, ans};
  endfunction

  // Divisor count and divisor sum of x, found by trial division.
  function automatic dcs_pkg::dcs_out_t divisor_answer(input logic [dcs_pkg::VAL_W-1:0] x);
    dcs_pkg::dcs_out_t ans;
    int unsigned       rem;
    int unsigned       p;
    int unsigned       e;
    longint unsigned   cnt;
    longint unsigned   total;
    longint unsigned   term;
    longint unsigned   pw;
    cnt   = 1;
    total = 1;
    rem   = x;
    p     = 2;
    while (rem > 1) begin
      // Past the square root, what is left is itself prime.
      if (p * p > rem) begin
        p = rem;
      end
      if (rem % p == 0) begin
        e    = 0;
        term = 1;
        pw   = 1;
        while (rem % p == 0) begin
          rem  = rem / p;
          pw   = pw * p;
          term = term + pw;
          e++;
        end
        cnt   = cnt * (e + 1);
        total = total * term;
      end
      p++;
    end
    ans.status        = dcs_pkg::STATUS_OK;
    ans.divisor_count = cnt[dcs_pkg::CNT_W-1:0];
    ans.divisor_sum   = total[dcs_pkg::SUM_W-1:0];
    return ans;
  endfunction

  // Watch the three channels at every rising edge.
  always @(posedge clk) begin
    dcs_pkg::dcs_out_t want;
    int unsigned       top;
    if (!rst_n) begin
      limit_reg   = '1;
      table_ready = 1'b0;
      answer_q.delete();
    end else begin
      // Result beat: compare with the oldest answer waiting.
      if (out_strobe) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result beat with no answer waiting, status", 0, out_data.status);
        end else begin
          want = answer_q.pop_front();
          if (out_data.status !== want.status) begin
            report_mismatch("status", want.status, out_data.status);
          end
          if (out_data.divisor_count !== want.divisor_count) begin
            report_mismatch("divisor_count", want.divisor_count, out_data.divisor_count);
          end
          if (out_data.divisor_sum !== want.divisor_sum) begin
            report_mismatch("divisor_sum", want.divisor_sum, out_data.divisor_sum);
          end
        end
      end

      // A limit write invalidates the table.
      if (cfg_valid && cfg_ready) begin
        limit_reg   = cfg_data;
        table_ready = 1'b0;
      end

      // Accepted input beat: predict its answer.
      if (start && !busy) begin
        top = (limit_reg > MAX_N) ? MAX_N : limit_reg;
        if (in_data.op == dcs_pkg::OP_BUILD) begin
          want        = '{dcs_pkg::STATUS_BUILT, '0, '0};
          table_ready = 1'b1;
        end else if (!table_ready) begin
          want = '{dcs_pkg::STATUS_NOT_BUILT, '0, '0};
        end else if (in_data.value == 0 || in_data.value > top) begin
          want = '{dcs_pkg::STATUS_RANGE, '0, '0};
        end else begin
          want = divisor_answer(in_data.value);
        end
        store_answer(want);
      end
    end
    pending = answer_q.size();
  end

endmodule

// ===== bench/tb_divisor_count_and_sum.sv =====
`timescale 1ns / 1ps
// Testbench top of the divisor count and sum block: stimulus, limit writes and the verdict.
module tb_divisor_count_and_sum;

  localparam int  VW          = dcs_pkg::VAL_W;
  localparam int  RAND_ITEMS  = 1550;
  localparam int  RAND_PHASES = 10;
  localparam int  CALM_ITEMS  = 150;
  localparam int  SMALL_TOP   = 255;
  localparam int  DRAIN_WAIT  = 50;
  localparam longint CYCLE_LIMIT = 8_000_000;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              start      = 1'b0;
  logic              busy;
  dcs_pkg::dcs_in_t  in_data    = '0;
  logic              out_strobe;
  dcs_pkg::dcs_out_t out_data;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [VW-1:0]     cfg_data   = '0;

  int     fail_count;
  int     pending;
  longint cycle_count = 0;
  int     items_left  = RAND_ITEMS;

  divisor_count_and_sum uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  dcs_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Presents one input beat, with an optional idle burst first, and returns
  // right after the edge that accepts it.
  task automatic send_item(input logic op, input logic [VW-1:0] value);
    dcs_pkg::dcs_in_t item;
    item.op    = op;
    item.value = value;
    if (items_left > CALM_ITEMS && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      // Half the bursts start once the block has gone idle.
      if ($urandom_range(0, 1) == 1) begin
        do @(negedge clk); while (busy);
        @(posedge clk);
      end
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_data <= item;
    start   <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  // Stops stimulus and waits until every answer has come back.
  task automatic drain;
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes the limit register once the block is idle.
  task automatic write_limit(input logic [VW-1:0] value);
    drain();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic query(input logic [VW-1:0] value);
    send_item(dcs_pkg::OP_QUERY, value);
  endtask

  // Random phase: new limit, a few early queries, a build, then mixed traffic.
  task automatic run_phase(input int phase, input int count);
    int unsigned top;
    int unsigned pick;
    case (phase)
      0:       top = 2;
      1:       top = 3;
      2:       top = $urandom_range(4, 64);
      3:       top = $urandom_range(4096, 8191);
      RAND_PHASES - 1: top = $urandom_range(16, SMALL_TOP);
      default: top = $urandom_range(65, 2047);
    endcase
    write_limit(top[VW-1:0]);
    repeat ($urandom_range(0, 3)) begin
      query(VW'($urandom_range(0, 65535)));
      items_left--;
    end
    send_item(dcs_pkg::OP_BUILD, VW'($urandom_range(0, 65535)));
    items_left--;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      // Rebuilds only where the table is small enough to refill quickly.
      if (pick < 4 && top <= SMALL_TOP) begin
        send_item(dcs_pkg::OP_BUILD, VW'($urandom_range(0, 65535)));
      end else if (pick < 14) begin
        if (pick < 7) begin
          query(16'd0);
        end else begin
          query(VW'($urandom_range(top + 1, 65535)));
        end
      end else if (pick < 22) begin
        query(VW'($urandom_range((top > 8) ? top - 8 : 1, top)));
      end else begin
        query(VW'($urandom_range(1, top)));
      end
      items_left--;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Queries before any build, the zero value among them.
    query(16'd5);
    query(16'd0);

    // Limit zero: the build completes and nothing is in range.
    write_limit(16'd0);
    send_item(dcs_pkg::OP_BUILD, 16'd0);
    query(16'd1);
    query(16'd0);

    // Limit one: only the value one is in range.
    write_limit(16'd1);
    query(16'd1);
    send_item(dcs_pkg::OP_BUILD, 16'd1);
    query(16'd1);
    query(16'd2);
    query(16'hFFFF);

    // Full range: extremes, a large prime, a power of two, rich composites.
    write_limit(16'hFFFF);
    send_item(dcs_pkg::OP_BUILD, 16'hFFFF);
    query(16'hFFFF);
    query(16'd1);
    query(16'd0);
    query(16'd65521);
    query(16'd32768);
    query(16'd55440);
    query(16'd45360);
    query(16'hAAAA);
    query(16'h5555);
    query(16'd2);

    // A limit write clears the built flag.
    write_limit(16'd100);
    query(16'd50);
    send_item(dcs_pkg::OP_BUILD, 16'h1234);
    query(16'd100);
    query(16'd101);
    query(16'd97);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      run_phase(ph, RAND_ITEMS / RAND_PHASES - 3);
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dcs_pkg.sv
rtl/dcs_ram.sv
rtl/dcs_div.sv
rtl/divisor_count_and_sum.sv
rtl/dcs_checker.sv
bench/dcs_checker.sv
bench/tb_divisor_count_and_sum.sv
